// ===== design/alhs_pkg.sv =====
// alhs_pkg: shared sizes, codes and types of the address lease hash set
// no dependencies; used by the channel interfaces, the unit and its checker

package alhs_pkg;

   // table geometry
   localparam int BUCKETS = 256;
   localparam int WAYS    = 4;

   localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   // payload widths
   localparam int OPCODE_W = 2;
   localparam int ADDR_W   = 64;
   localparam int STATUS_W = 2;

   // byte sum of 16 bytes is at most 4080
   localparam int HALF_SUM_W = 11;
   localparam int SUM_W      = 12;

   // bucket = sum mod BUCKETS through a reciprocal; exact for sums below 4096
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = RECIP_SHIFT;
   localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + BUCKETS - 1) / BUCKETS;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int QB_W        = 2 * SUM_W + 1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LEASE   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_QUERY   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_ALREADY   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_QUOT,
      S_REM,
      S_READ,
      S_WRITE
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] key_high;
      logic [ADDR_W-1:0] key_low;
   } slot_type;

   typedef slot_type [WAYS-1:0] row_type;

endpackage

// ===== design/alhs_if.sv =====
// alhs_req_if and alhs_rsp_if: valid/ready channels of the lease hash set
// depends on alhs_pkg for payload widths

interface alhs_req_if;
   import alhs_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ADDR_W-1:0]   addr_high;
   logic [ADDR_W-1:0]   addr_low;

   modport source (output valid, output opcode, output addr_high, output addr_low,
                   input ready);
   modport sink   (input valid, input opcode, input addr_high, input addr_low,
                   output ready);
endinterface

interface alhs_rsp_if;
   import alhs_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                was_present;

   modport source (output valid, output status, output was_present, input ready);
   modport sink   (input valid, input status, input was_present, output ready);
endinterface

// ===== design/address_lease_hash_set_unit.sv =====
// address_lease_hash_set_unit: hashed set of leased 128-bit addresses
// depends on alhs_pkg and the channel interfaces in alhs_if.sv

// Keeps up to BUCKETS x WAYS leased IPv6 addresses. The bucket of an address is
// the sum of its 16 bytes modulo BUCKETS; each bucket is one row of a single
// synchronous memory holding WAYS slots (valid bit plus 128-bit key). A
// transaction on req carries an opcode (lease, release, query; code 3 acts as a
// query) and the address, and gives exactly one transaction on rsp with status
// and was_present. After reset the block sweeps the memory once, one row per
// cycle, with req.ready low. It then handles one transaction at a time: accept
// with byte sum, quotient, remainder, row read, compare and write-back; the next
// transaction is accepted only after the write-back. A waiting result does not
// block acceptance of the next transaction; only the write-back stalls while the
// previous result is still held.

module address_lease_hash_set_unit (
   input  logic       clock,
   input  logic       reset,
   alhs_req_if.sink   req,
   alhs_rsp_if.source rsp
);
   import alhs_pkg::*;

   // sum of the eight bytes of one 64-bit half
   function automatic logic [HALF_SUM_W-1:0] byte_sum8(input logic [ADDR_W-1:0] v);
      logic [HALF_SUM_W-1:0] s;
      s = '0;
      for (int k = 0; k < 8; k++) begin
         s = s + HALF_SUM_W'(v[8*k +: 8]);
      end
      return s;
   endfunction

   // control state
   state_type        state_ff, state_in;
   logic [BKT_W-1:0] clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // captured transaction and hash pipeline
   logic [OPCODE_W-1:0] op_ff;
   logic [ADDR_W-1:0]   key_high_ff;
   logic [ADDR_W-1:0]   key_low_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]    quot_ff, quot_in;
   logic [BKT_W-1:0]    bucket_ff, bucket_in;
   logic [PROD_W-1:0]   prod;
   logic [QB_W-1:0]     rem;

   // result register
   status_type status_ff, status_in;
   logic       present_ff;

   // row memory and its read register
   row_type          store_mem [BUCKETS];
   row_type          row_ff;
   row_type          new_row;
   row_type          mem_wdata;
   logic [BKT_W-1:0] mem_waddr;
   logic             mem_we;
   logic             mem_re;

   // way search
   logic             hit_any, free_any;
   logic [WAY_W-1:0] hit_way, free_way;
   logic             row_change;

   // handshake strobes
   logic capture;
   logic rsp_load;

   assign sum_in = SUM_W'(byte_sum8(req.addr_high)) + SUM_W'(byte_sum8(req.addr_low));

   // quotient by reciprocal multiply, then remainder
   assign prod    = PROD_W'(sum_ff) * PROD_W'(RECIP);
   assign quot_in = prod[RECIP_SHIFT +: SUM_W];
   assign rem     = QB_W'(sum_ff) - QB_W'(quot_ff) * QB_W'(BUCKETS);
   assign bucket_in = rem[BKT_W-1:0];

   // compare all ways of the row; lowest way wins
   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_ff[w].valid && row_ff[w].key_high == key_high_ff &&
             row_ff[w].key_low == key_low_ff) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!row_ff[w].valid) begin
            free_any = 1'b1;
            free_way = WAY_W'(w);
         end
      end
   end

   // result and updated row
   always_comb begin
      new_row    = row_ff;
      row_change = 1'b0;
      status_in  = ST_DONE;
      case (op_ff)
         OP_LEASE: begin
            if (hit_any) begin
               status_in = ST_ALREADY;
            end else if (free_any) begin
               new_row[free_way] = '{valid: 1'b1, key_high: key_high_ff,
                                     key_low: key_low_ff};
               row_change = 1'b1;
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_RELEASE: begin
            if (hit_any) begin
               new_row[hit_way].valid = 1'b0;
               row_change = 1'b1;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            // query and the unused code: report presence only
            status_in = ST_DONE;
         end
      endcase
   end

   // sequencer: next state and strobes
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      mem_we    = 1'b0;
      mem_waddr = bucket_ff;
      mem_wdata = new_row;
      mem_re    = 1'b0;
      req.ready = 1'b0;
      capture   = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // zero one row per cycle after reset
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               capture  = 1'b1;
               state_in = S_QUOT;
            end
         end
         S_QUOT: begin
            state_in = S_REM;
         end
         S_REM: begin
            state_in = S_READ;
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // write-back and result go together, once the result slot is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               mem_we   = row_change;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (capture) begin
         op_ff       <= req.opcode;
         key_high_ff <= req.addr_high;
         key_low_ff  <= req.addr_low;
         sum_ff      <= sum_in;
      end
      if (state_ff == S_QUOT) begin
         quot_ff <= quot_in;
      end
      if (state_ff == S_REM) begin
         bucket_ff <= bucket_in;
      end
      if (rsp_load) begin
         status_ff  <= status_in;
         present_ff <= hit_any;
      end
   end

   // row memory: one write port, one registered read port; a read always
   // follows the previous write-back with the idle, quotient and remainder states between, so no forwarding
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         row_ff <= store_mem[bucket_ff];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.was_present = present_ff;

endmodule

// ===== design/alhs_checker.sv =====
// alhs_checker: port-level assertions for address_lease_hash_set_unit
// depends on alhs_pkg; bound to address_lease_hash_set_unit at the end of this file

module alhs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [alhs_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_was_present
);
   import alhs_pkg::*;

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one transaction at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // already leased implies present
   a_already_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ALREADY) |-> rsp_was_present)
      else $error("already leased without presence");

   // full bucket and missed release imply absent
   a_absent_codes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND))
      |-> !rsp_was_present)
      else $error("absence status with presence flag");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_was_present)))
      else $error("stalled result changed");

endmodule

bind address_lease_hash_set_unit alhs_checker u_alhs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_was_present (rsp.was_present)
);

// ===== tb/address_lease_hash_set_unit_test.sv =====
// address_lease_hash_set_unit_test: self-checking bench for the lease hash set unit
// depends on alhs_pkg, the channel interfaces in alhs_if.sv and the unit itself
`timescale 1ns / 100ps

module address_lease_hash_set_unit_test;
   import alhs_pkg::*;

   // opcode 3 has no enum member; the unit treats it as a query
   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

   localparam int SLOTS       = BUCKETS * WAYS;
   // clearing sweep plus 420 transactions under heavy stalls, taken many times over
   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE   = 16;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [ADDR_W-1:0]   addr_high;
      logic [ADDR_W-1:0]   addr_low;
   } lease_request_type;

   typedef struct {
      status_type status;
      logic       was_present;
   } lease_outcome_type;

   logic clock;
   logic reset;

   alhs_req_if req_if ();
   alhs_rsp_if rsp_if ();

   address_lease_hash_set_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // mirror of the lease table
   logic              lease_live [SLOTS];
   logic [ADDR_W-1:0] lease_high [SLOTS];
   logic [ADDR_W-1:0] lease_low  [SLOTS];

   lease_request_type pending_requests [$];
   lease_outcome_type expected_outcomes [$];

   // addresses reused by the random part so that hits, duplicates and full buckets occur
   logic [ADDR_W-1:0] pool_high [POOL_SIZE];
   logic [ADDR_W-1:0] pool_low  [POOL_SIZE];

   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_sender;
   bit  req_taken;
   int  mismatch_count;
   int  cycle_count;

   // clock, with every block input known from time zero
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid     = 1'b0;
      req_if.opcode    = OP_QUERY;
      req_if.addr_high = '0;
      req_if.addr_low  = '0;
      rsp_if.ready     = 1'b0;
      forever #5 clock = ~clock;
   end

   // bucket of an address: sum of its 16 bytes modulo the bucket count
   function automatic int bucket_index(logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo);
      int sum;
      sum = 0;
      for (int k = 0; k < 8; k++)
         sum += int'(hi[8*k +: 8]) + int'(lo[8*k +: 8]);
      return sum % BUCKETS;
   endfunction

   function automatic logic [ADDR_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // random address steered into a given bucket by adjusting its last byte
   task automatic address_in_bucket(input int target, output logic [ADDR_W-1:0] hi,
                                    output logic [ADDR_W-1:0] lo);
      hi = random_word();
      lo = random_word();
      for (int d = 0; d < 256; d++) begin
         lo[7:0] = d[7:0];
         if (bucket_index(hi, lo) == target)
            break;
      end
   endtask

   // applies one transaction to the mirror and returns the response it must give
   function automatic lease_outcome_type apply_lease_op(lease_request_type r);
      lease_outcome_type o;
      int base;
      int hit;
      int free_way;
      base = bucket_index(r.addr_high, r.addr_low) * WAYS;
      hit = -1;
      free_way = -1;
      // scan from the top so the lowest way wins
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (lease_live[base + w] && lease_high[base + w] == r.addr_high &&
             lease_low[base + w] == r.addr_low)
            hit = base + w;
         if (!lease_live[base + w])
            free_way = w;
      end
      o.was_present = (hit >= 0);
      o.status = ST_DONE;
      if (r.opcode == OP_LEASE) begin
         if (hit >= 0) begin
            o.status = ST_ALREADY;
         end else if (free_way < 0) begin
            o.status = ST_FULL;
         end else begin
            lease_live[base + free_way] = 1'b1;
            lease_high[base + free_way] = r.addr_high;
            lease_low[base + free_way]  = r.addr_low;
         end
      end else if (r.opcode == OP_RELEASE) begin
         if (hit >= 0)
            lease_live[hit] = 1'b0;
         else
            o.status = ST_NOT_FOUND;
      end
      return o;
   endfunction

   task automatic note_mismatch(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   task automatic queue_request(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] hi,
                                logic [ADDR_W-1:0] lo);
      lease_request_type r;
      r.opcode    = op;
      r.addr_high = hi;
      r.addr_low  = lo;
      pending_requests.push_back(r);
   endtask

   // wait until every queued transaction is sent and answered
   task automatic drain();
      while (pending_requests.size() != 0 || req_if.valid || expected_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // pool: two hot buckets holding more addresses than ways, plus a few loners
   task automatic refill_pool();
      int hot_a;
      int hot_b;
      hot_a = $urandom_range(BUCKETS - 1);
      hot_b = $urandom_range(BUCKETS - 1);
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < 6)
            address_in_bucket(hot_a, pool_high[i], pool_low[i]);
         else if (i < 12)
            address_in_bucket(hot_b, pool_high[i], pool_low[i]);
         else
            address_in_bucket($urandom_range(BUCKETS - 1), pool_high[i], pool_low[i]);
      end
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      int pick;
      int roll;
      logic [OPCODE_W-1:0] op;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      refill_pool();
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 85) begin
            // well-formed traffic on pooled addresses
            pick = $urandom_range(POOL_SIZE - 1);
            roll = $urandom_range(99);
            if (roll < 40)      op = OP_LEASE;
            else if (roll < 70) op = OP_RELEASE;
            else if (roll < 90) op = OP_QUERY;
            else                op = OP_SPARE;
            queue_request(op, pool_high[pick], pool_low[pick]);
         end else begin
            // noise: fresh address, any opcode
            queue_request(OPCODE_W'($urandom_range(3)), random_word(), random_word());
         end
      end
      drain();
   endtask

   // stimulus: directed checks, then four random phases with varied idling and stalls
   initial begin
      logic [ADDR_W-1:0] ones_hi;
      logic [ADDR_W-1:0] ones_lo;
      logic [ADDR_W-1:0] fill_hi [3];
      logic [ADDR_W-1:0] fill_lo [3];
      logic [ADDR_W-1:0] late_hi;
      logic [ADDR_W-1:0] late_lo;
      logic [ADDR_W-1:0] over_hi;
      logic [ADDR_W-1:0] over_lo;
      int top_bucket;

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_sender    = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
         lease_live[s] = 1'b0;
         lease_high[s] = '0;
         lease_low[s]  = '0;
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all-zero address: lease, duplicate, query, release, missed release, query
      queue_request(OP_LEASE,   '0, '0);
      queue_request(OP_LEASE,   '0, '0);
      queue_request(OP_QUERY,   '0, '0);
      queue_request(OP_RELEASE, '0, '0);
      queue_request(OP_RELEASE, '0, '0);
      queue_request(OP_QUERY,   '0, '0);

      // all-ones address, spare opcode before and after its lease
      ones_hi = '1;
      ones_lo = '1;
      queue_request(OP_SPARE, ones_hi, ones_lo);
      queue_request(OP_LEASE, ones_hi, ones_lo);
      queue_request(OP_SPARE, ones_hi, ones_lo);

      // fill the all-ones bucket, overflow it, free one way and refill it
      top_bucket = bucket_index(ones_hi, ones_lo);
      for (int i = 0; i < 3; i++) begin
         address_in_bucket(top_bucket, fill_hi[i], fill_lo[i]);
         queue_request(OP_LEASE, fill_hi[i], fill_lo[i]);
      end
      address_in_bucket(top_bucket, late_hi, late_lo);
      address_in_bucket(top_bucket, over_hi, over_lo);
      queue_request(OP_LEASE,   late_hi, late_lo);
      queue_request(OP_RELEASE, fill_hi[0], fill_lo[0]);
      queue_request(OP_QUERY,   fill_hi[0], fill_lo[0]);
      queue_request(OP_LEASE,   late_hi, late_lo);
      queue_request(OP_LEASE,   over_hi, over_lo);
      queue_request(OP_QUERY,   late_hi, late_lo);
      queue_request(OP_RELEASE, over_hi, over_lo);
      queue_request(OP_QUERY,   ones_hi, ones_lo);

      // random traffic is queued only once the directed part is fully answered
      drain();

      run_phase(0,  0,  100);
      run_phase(79, 0,  100);
      run_phase(0,  79, 100);
      run_phase(11, 11, 100);

      // a result still in flight would show up here
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // request driver: a new transaction is presented only once the last one is taken
   always @(negedge clock) begin
      lease_request_type r;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_requests.size() != 0 && !hold_sender &&
             $urandom_range(99) >= send_idle_pct) begin
            r = pending_requests.pop_front();
            req_if.valid     <= 1'b1;
            req_if.opcode    <= r.opcode;
            req_if.addr_high <= r.addr_high;
            req_if.addr_low  <= r.addr_low;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response sink: random back-pressure
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: predicts on request transactions, checks response transactions
   always @(posedge clock) begin
      lease_request_type r;
      lease_outcome_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_outcomes.size() == 0) begin
               note_mismatch("unexpected response, status", rsp_if.status, -1);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_if.status !== want.status)
                  note_mismatch("status", rsp_if.status, want.status);
               if (rsp_if.was_present !== want.was_present)
                  note_mismatch("was_present", rsp_if.was_present, want.was_present);
            end
         end
         if (req_if.valid && req_if.ready) begin
            r.opcode    = req_if.opcode;
            r.addr_high = req_if.addr_high;
            r.addr_low  = req_if.addr_low;
            expected_outcomes.push_back(apply_lease_op(r));
         end
      end
   end

   initial begin
      mismatch_count = 0;
      cycle_count    = 0;
      req_taken      = 1'b0;
   end

endmodule
